// ===== hdl/llrs_pkg.sv =====
// llrs_pkg: shared constants and types for the link loss recovery supervisor
// register indexes, reset values and port widths; no dependencies

package llrs_pkg;

    localparam int TimeWidth     = 32;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 32;
    localparam int RebootWidth   = 31;

    typedef logic [TimeWidth-1:0]     time_ms_t;
    typedef logic [CfgIndexWidth-1:0] cfg_index_t;
    typedef logic [CfgDataWidth-1:0]  cfg_data_t;
    typedef logic [RebootWidth-1:0]   reboot_ms_t;

    // configuration register indexes
    localparam cfg_index_t CFG_RECOVERY_ENABLE = 3'd0;
    localparam cfg_index_t CFG_CHECK_INTERVAL  = 3'd1;
    localparam cfg_index_t CFG_REBOOT_AFTER    = 3'd2;
    localparam cfg_index_t CFG_RETRY_WINDOW    = 3'd3;
    localparam cfg_index_t CFG_GRACE_DELAY     = 3'd4;
    localparam cfg_index_t CFG_RETRY_PERIOD    = 3'd5;

    // configuration reset values
    localparam logic       RST_RECOVERY_ENABLE = 1'b1;
    localparam time_ms_t   RST_CHECK_INTERVAL  = 32'd1000;
    localparam reboot_ms_t RST_REBOOT_AFTER    = 31'd0;
    localparam time_ms_t   RST_RETRY_WINDOW    = 32'hFFFF_FFFF;
    localparam time_ms_t   RST_GRACE_DELAY     = 32'd0;
    localparam time_ms_t   RST_RETRY_PERIOD    = 32'd5000;

    // zero timestamp marks nothing recorded
    localparam time_ms_t   NO_TIME = 32'd0;

    typedef struct packed {
        logic evaluated;
        logic recovered;
        logic lost;
        logic reboot_request;
        logic reconnect_request;
    } flags_t;

endpackage

// ===== hdl/link_loss_recovery_supervisor_top.sv =====
// link_loss_recovery_supervisor_top: poll throttle, outage tracking and
// reboot / reconnect decisions; depends on llrs_pkg
//
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_stall   now_ms, station_mode, link_up
//   out       source     out_valid/out_stall evaluated, recovered, lost,
//                                            reboot_request, reconnect_request
//   cfg       sink       cfg_write           cfg_index, cfg_data
//
// a poll passes from transfer to result through the input register, then the
// decision logic (wrapping subtracts and compares) into the result register
// one poll per cycle unless the output stalls; the supervisor state is
// updated as a poll enters the result register, so the next poll sees it at once
// rst_n is asynchronous, clears the control and supervisor state and loads
// the configuration defaults
// a stall at the output holds the result; the input register still takes a
// poll while the result waits, and in_stall rises only when both are full

module link_loss_recovery_supervisor_top
    import llrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  time_ms_t   now_ms,
    input  logic       station_mode,
    input  logic       link_up,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       evaluated,
    output logic       recovered,
    output logic       lost,
    output logic       reboot_request,
    output logic       reconnect_request,

    input  logic       cfg_write,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data
);

    // configuration
    logic       recovery_enable_reg;
    time_ms_t   check_interval_reg;
    reboot_ms_t reboot_after_reg;
    time_ms_t   retry_window_reg;
    time_ms_t   grace_delay_reg;
    time_ms_t   retry_period_reg;

    // supervisor state
    time_ms_t   last_poll_time_reg, last_poll_time_next;
    time_ms_t   outage_start_reg,   outage_start_next;
    time_ms_t   last_up_time_reg,   last_up_time_next;
    time_ms_t   last_retry_time_reg, last_retry_time_next;

    // input register
    logic       in_vld_reg;
    time_ms_t   now_reg;
    logic       station_reg;
    logic       up_reg;

    // result register
    logic       out_vld_reg;
    flags_t     flags_reg, flags_next;

    logic       in_take;
    logic       advance;

    time_ms_t   since_poll;
    time_ms_t   outage_base;
    time_ms_t   down_for;
    time_ms_t   since_retry;
    logic       reboot_hit;
    logic       window_ok;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recovery_enable_reg <= RST_RECOVERY_ENABLE;
            check_interval_reg  <= RST_CHECK_INTERVAL;
            reboot_after_reg    <= RST_REBOOT_AFTER;
            retry_window_reg    <= RST_RETRY_WINDOW;
            grace_delay_reg     <= RST_GRACE_DELAY;
            retry_period_reg    <= RST_RETRY_PERIOD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RECOVERY_ENABLE: recovery_enable_reg <= cfg_data[0];
                CFG_CHECK_INTERVAL:  check_interval_reg  <= cfg_data;
                CFG_REBOOT_AFTER:    reboot_after_reg    <= cfg_data[RebootWidth-1:0];
                CFG_RETRY_WINDOW:    retry_window_reg    <= cfg_data;
                CFG_GRACE_DELAY:     grace_delay_reg     <= cfg_data;
                CFG_RETRY_PERIOD:    retry_period_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // decision logic on the registered poll
    always_comb
    begin
        since_poll  = now_reg - last_poll_time_reg;
        outage_base = (outage_start_reg == NO_TIME) ? now_reg : outage_start_reg;
        down_for    = now_reg - outage_base;
        since_retry = now_reg - last_retry_time_reg;
        reboot_hit  = (reboot_after_reg != '0) && (down_for >= {1'b0, reboot_after_reg});
        // negative window retries forever, zero never
        window_ok   = (retry_window_reg != '0)
                      && (retry_window_reg[TimeWidth-1] || (down_for <= retry_window_reg));

        flags_next           = '0;
        last_poll_time_next  = last_poll_time_reg;
        outage_start_next    = outage_start_reg;
        last_up_time_next    = last_up_time_reg;
        last_retry_time_next = last_retry_time_reg;

        if (since_poll >= check_interval_reg)
        begin
            flags_next.evaluated = 1'b1;
            last_poll_time_next  = now_reg;
            if (recovery_enable_reg && station_reg)
            begin
                if (up_reg)
                begin
                    flags_next.recovered = (outage_start_reg != NO_TIME)
                                           || (last_up_time_reg == NO_TIME);
                    last_up_time_next    = now_reg;
                    outage_start_next    = NO_TIME;
                end
                else
                begin
                    if (outage_start_reg == NO_TIME)
                    begin
                        outage_start_next = now_reg;
                        flags_next.lost   = 1'b1;
                    end
                    if (reboot_hit)
                    begin
                        flags_next.reboot_request = 1'b1;
                    end
                    else if (window_ok && (down_for >= grace_delay_reg)
                             && (since_retry >= retry_period_reg))
                    begin
                        flags_next.reconnect_request = 1'b1;
                        last_retry_time_next         = now_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            last_poll_time_reg  <= '0;
            outage_start_reg    <= '0;
            last_up_time_reg    <= '0;
            last_retry_time_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg         <= 1'b1;
                last_poll_time_reg  <= last_poll_time_next;
                outage_start_reg    <= outage_start_next;
                last_up_time_reg    <= last_up_time_next;
                last_retry_time_reg <= last_retry_time_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg     <= now_ms;
            station_reg <= station_mode;
            up_reg      <= link_up;
        end
        if (advance)
        begin
            flags_reg <= flags_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign evaluated         = flags_reg.evaluated;
    assign recovered         = flags_reg.recovered;
    assign lost              = flags_reg.lost;
    assign reboot_request    = flags_reg.reboot_request;
    assign reconnect_request = flags_reg.reconnect_request;

    // a throttled poll reports nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evaluated |-> !(recovered || lost || reboot_request || reconnect_request))
        else $error("flags set on a throttled poll");

    // reboot and reconnect are exclusive, as are recovery and loss
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reboot_request && reconnect_request) && !(recovered && lost))
        else $error("conflicting result flags");

    // a recovery transfer clears the outage record
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && flags_next.recovered |=> outage_start_reg == NO_TIME)
        else $error("outage not cleared on recovery");

    // a reconnect request stamps the retry time with the poll time
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && flags_next.reconnect_request |=> last_retry_time_reg == $past(now_reg))
        else $error("retry time not recorded");

    // state only moves when a poll goes into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(last_poll_time_reg) && $stable(outage_start_reg))
        else $error("state changed without a poll");

endmodule
